@@ hw/rtl/fifo_batch_promotion_replacement_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef FIFO_BATCH_PROMOTION_REPLACEMENT_UNIT_ASSERT_SVH
`define FIFO_BATCH_PROMOTION_REPLACEMENT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define FBP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("fbp assertion failed");
`define FBP_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fbp assertion failed");
`else
`define FBP_ASSERT(lbl, clk, rstn, prop)
`define FBP_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

@@ hw/rtl/fbp_pkg.sv @@
// ----------------------------------------------------------------------------
// fbp_pkg
// Types and constants of the batch promotion replacement unit.
// ----------------------------------------------------------------------------
`default_nettype none
package fbp_pkg;

  localparam int ID_W    = 64;
  localparam int CAP_W   = 11;
  localparam int IVAL_W  = 16;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  localparam logic REQ_ACCESS = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  localparam logic CFG_IDX_CAPACITY = 1'b0;
  localparam logic CFG_IDX_INTERVAL = 1'b1;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 11'd1024;
  localparam logic [IVAL_W-1:0] IVAL_RESET = 16'd204;
  localparam logic [IVAL_W-1:0] INS_MAX    = 16'hFFFF;

  typedef struct packed {
    logic            req_type;
    logic [ID_W-1:0] object_id;
  } fbp_req_t;

  typedef struct packed {
    logic            hit;
    logic            victim_valid;
    logic [ID_W-1:0] victim_id;
    logic            batch_promoted;
  } fbp_rsp_t;

  typedef struct packed {
    logic [CAP_W-1:0]  capacity_in_use;
    logic [IVAL_W-1:0] promotion_interval;
  } fbp_cfg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_HIT,
    ST_EV_CHK,
    ST_EV_LOAD,
    ST_UNLINK,
    ST_PUSH,
    ST_INSERT,
    ST_PR_START,
    ST_PR_READ,
    ST_PR_WAIT,
    ST_DONE
  } fbp_state_e;

  typedef enum logic [1:0] {
    MD_ACCESS,
    MD_REMOVE,
    MD_EVICT,
    MD_PROMO
  } fbp_mode_e;

endpackage
`default_nettype wire

@@ hw/rtl/fbp_cfg.sv @@
// ----------------------------------------------------------------------------
// fbp_cfg
// APB register file: capacity in use and promotion interval.
// ----------------------------------------------------------------------------
`default_nettype none
module fbp_cfg
  import fbp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output fbp_cfg_t               cfg_o
);

  logic [CAP_W-1:0]  cap_q, cap_d;
  logic [IVAL_W-1:0] ival_q, ival_d;
  logic              wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_comb begin
    cap_d  = cap_q;
    ival_d = ival_q;
    if (wr) begin
      unique case (paddr[2])
        CFG_IDX_CAPACITY: cap_d  = pwdata[CAP_W-1:0];
        CFG_IDX_INTERVAL: ival_d = pwdata[IVAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      CFG_IDX_CAPACITY: prdata = CFG_DW'(cap_q);
      CFG_IDX_INTERVAL: prdata = CFG_DW'(ival_q);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CAP_RESET;
      ival_q <= IVAL_RESET;
    end else begin
      cap_q  <= cap_d;
      ival_q <= ival_d;
    end
  end

  assign cfg_o.capacity_in_use    = cap_q;
  assign cfg_o.promotion_interval = ival_q;

endmodule
`default_nettype wire

@@ hw/rtl/fifo_batch_promotion_replacement_unit.sv @@
// ----------------------------------------------------------------------------
// fifo_batch_promotion_replacement_unit
// FIFO set of object ids with lazy promotion through a hit ring.
//
//  channel | direction | handshake              | payload
//  request | in        | start, busy            | req_i  (fbp_req_t)
//  result  | out       | done_o (one cycle)     | rsp_o  (fbp_rsp_t)
//  config  | in/out    | psel, penable, pwrite  | paddr, pwdata, prdata
//
//  A lookup walks the slot memory one slot per cycle, up to every slot; a
//  miss then checks, loads and unlinks the tail per eviction and inserts.
//  A batch promotion reads each ring entry, looks it up and relinks a found
//  entry to the head. After reset a clearing pass over every slot holds busy
//  high. Results cannot be stalled; busy drops after done_o.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fifo_batch_promotion_replacement_unit_assert.svh"
module fifo_batch_promotion_replacement_unit
  import fbp_pkg::*;
#(
  parameter int CAPACITY       = 1024,
  parameter int HIT_RING_DEPTH = 4096
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire fbp_req_t          req_i,
  output logic                   done_o,
  output fbp_rsp_t               rsp_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int RW = $clog2(HIT_RING_DEPTH);
  localparam int FW = $clog2(HIT_RING_DEPTH + 1);
  localparam logic [IW-1:0] LAST_SLOT = IW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_MAX   = CW'(CAPACITY);
  localparam logic [RW-1:0] LAST_POS  = RW'(HIT_RING_DEPTH - 1);
  localparam logic [FW-1:0] RING_FULL = FW'(HIT_RING_DEPTH);

  fbp_cfg_t cfg;

  fbp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // memories
  logic [ID_W:0]   tag_mem   [CAPACITY];
  logic [IW-1:0]   older_mem [CAPACITY];
  logic [IW-1:0]   newer_mem [CAPACITY];
  logic [ID_W-1:0] ring_mem  [HIT_RING_DEPTH];

  logic            tag_we, older_we, newer_we, ring_we;
  logic [IW-1:0]   tag_wa, older_wa, newer_wa, slot_ra;
  logic [ID_W:0]   tag_wd;
  logic [IW-1:0]   older_wd, newer_wd;
  logic [RW-1:0]   ring_wa;
  logic [ID_W-1:0] ring_wd;
  logic [ID_W:0]   tag_rd_q;
  logic [IW-1:0]   older_rd_q, newer_rd_q;
  logic [ID_W-1:0] ring_rd_q;

  always_ff @(posedge clk_i) begin
    if (tag_we) tag_mem[tag_wa] <= tag_wd;
    tag_rd_q <= tag_mem[slot_ra];
  end

  always_ff @(posedge clk_i) begin
    if (older_we) older_mem[older_wa] <= older_wd;
    older_rd_q <= older_mem[slot_ra];
  end

  always_ff @(posedge clk_i) begin
    if (newer_we) newer_mem[newer_wa] <= newer_wd;
    newer_rd_q <= newer_mem[slot_ra];
  end

  // control state
  fbp_state_e      state_q, state_d;
  fbp_mode_e       mode_q, mode_d;
  logic [IW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]   occ_q, occ_d;
  logic [RW-1:0]   wi_q, wi_d, pos_q, pos_d;
  logic [FW-1:0]   fill_q, fill_d, cnt_q, cnt_d;
  logic [IVAL_W-1:0] ins_q, ins_d;
  logic [IW-1:0]   scan_q, scan_d, chk_idx_q, chk_idx_d;
  logic            chk_vld_q, chk_vld_d, free_vld_q, free_vld_d;

  // payload
  logic [ID_W-1:0] key_q, key_d;
  logic [IW-1:0]   s_q, s_d, o_q, o_d, n_q, n_d, free_q, free_d;
  fbp_rsp_t        rsp_q, rsp_d;

  logic [CW-1:0]     cap_eff;
  logic [IVAL_W-1:0] ival_eff;
  logic              match;

  always_ff @(posedge clk_i) begin
    if (ring_we) ring_mem[ring_wa] <= ring_wd;
    ring_rd_q <= ring_mem[pos_q];
  end

  always_comb begin
    if (cfg.capacity_in_use == '0) begin
      cap_eff = CW'(1);
    end else if (32'(cfg.capacity_in_use) > 32'(CAPACITY)) begin
      cap_eff = CAP_MAX;
    end else begin
      cap_eff = CW'(cfg.capacity_in_use);
    end
    ival_eff = (cfg.promotion_interval == '0) ? IVAL_W'(1) : cfg.promotion_interval;
  end

  assign match = tag_rd_q[ID_W] && (tag_rd_q[ID_W-1:0] == key_q);

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    head_d     = head_q;
    tail_d     = tail_q;
    occ_d      = occ_q;
    wi_d       = wi_q;
    pos_d      = pos_q;
    fill_d     = fill_q;
    cnt_d      = cnt_q;
    ins_d      = ins_q;
    scan_d     = scan_q;
    chk_idx_d  = chk_idx_q;
    chk_vld_d  = chk_vld_q;
    free_vld_d = free_vld_q;
    key_d      = key_q;
    s_d        = s_q;
    o_d        = o_q;
    n_d        = n_q;
    free_d     = free_q;
    rsp_d      = rsp_q;
    tag_we     = 1'b0;
    tag_wa     = s_q;
    tag_wd     = '0;
    older_we   = 1'b0;
    older_wa   = n_q;
    older_wd   = o_q;
    newer_we   = 1'b0;
    newer_wa   = o_q;
    newer_wd   = n_q;
    ring_we    = 1'b0;
    ring_wa    = wi_q;
    ring_wd    = key_q;
    slot_ra    = scan_q;

    unique case (state_q)
      ST_CLEAR: begin
        tag_we = 1'b1;
        tag_wa = scan_q;
        scan_d = scan_q + IW'(1);
        if (scan_q == LAST_SLOT) begin
          scan_d  = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          key_d      = req_i.object_id;
          mode_d     = (req_i.req_type == REQ_REMOVE) ? MD_REMOVE : MD_ACCESS;
          rsp_d      = '0;
          scan_d     = '0;
          chk_vld_d  = 1'b0;
          free_vld_d = 1'b0;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_d    = scan_q + IW'(1);
        chk_vld_d = 1'b1;
        chk_idx_d = scan_q;
        if (chk_vld_q) begin
          if (!tag_rd_q[ID_W] && !free_vld_q) begin
            free_d     = chk_idx_q;
            free_vld_d = 1'b1;
          end
          if (match || chk_idx_q == LAST_SLOT) begin
            s_d       = chk_idx_q;
            o_d       = older_rd_q;
            n_d       = newer_rd_q;
            chk_vld_d = 1'b0;
            scan_d    = '0;
            case (mode_q)
              MD_ACCESS: begin
                if (match) begin
                  rsp_d.hit = 1'b1;
                  state_d   = ST_HIT;
                end else begin
                  if (ins_q != INS_MAX) ins_d = ins_q + IVAL_W'(1);
                  state_d = ST_EV_CHK;
                end
              end
              MD_REMOVE: begin
                if (match) begin
                  rsp_d.hit = 1'b1;
                  state_d   = ST_UNLINK;
                end else begin
                  state_d = ST_DONE;
                end
              end
              default: begin
                state_d = (match && chk_idx_q != head_q) ? ST_UNLINK : ST_PR_READ;
              end
            endcase
          end
        end
      end
      ST_HIT: begin
        ring_we = 1'b1;
        wi_d    = (wi_q == LAST_POS) ? '0 : wi_q + RW'(1);
        if (fill_q != RING_FULL) fill_d = fill_q + FW'(1);
        if (ins_q >= ival_eff) begin
          rsp_d.batch_promoted = 1'b1;
          state_d              = ST_PR_START;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_PR_START: begin
        if (32'(wi_q) >= 32'(fill_q)) begin
          pos_d = RW'(32'(wi_q) - 32'(fill_q));
        end else begin
          pos_d = RW'(32'(wi_q) + 32'(HIT_RING_DEPTH) - 32'(fill_q));
        end
        cnt_d   = fill_q;
        mode_d  = MD_PROMO;
        state_d = ST_PR_READ;
      end
      ST_PR_READ: begin
        if (cnt_q == '0) begin
          fill_d  = '0;
          wi_d    = '0;
          ins_d   = '0;
          state_d = ST_DONE;
        end else begin
          state_d = ST_PR_WAIT;
        end
      end
      ST_PR_WAIT: begin
        key_d     = ring_rd_q;
        pos_d     = (pos_q == LAST_POS) ? '0 : pos_q + RW'(1);
        cnt_d     = cnt_q - FW'(1);
        scan_d    = '0;
        chk_vld_d = 1'b0;
        state_d   = ST_SCAN;
      end
      ST_UNLINK: begin
        if (s_q == head_q) head_d = o_q;
        else older_we = 1'b1;
        if (s_q == tail_q) tail_d = n_q;
        else newer_we = 1'b1;
        if (mode_q != MD_PROMO) begin
          tag_we = 1'b1;
          occ_d  = occ_q - CW'(1);
        end
        case (mode_q)
          MD_REMOVE: state_d = ST_DONE;
          MD_EVICT:  state_d = ST_EV_CHK;
          default:   state_d = ST_PUSH;
        endcase
      end
      ST_PUSH: begin
        older_we = 1'b1;
        older_wa = s_q;
        older_wd = head_q;
        newer_we = 1'b1;
        newer_wa = head_q;
        newer_wd = s_q;
        head_d   = s_q;
        state_d  = ST_PR_READ;
      end
      ST_EV_CHK: begin
        slot_ra = tail_q;
        if (occ_q >= cap_eff && occ_q != '0) state_d = ST_EV_LOAD;
        else state_d = ST_INSERT;
      end
      ST_EV_LOAD: begin
        s_d                = tail_q;
        o_d                = older_rd_q;
        n_d                = newer_rd_q;
        rsp_d.victim_valid = 1'b1;
        rsp_d.victim_id    = tag_rd_q[ID_W-1:0];
        if (!free_vld_q) free_d = tail_q;
        mode_d             = MD_EVICT;
        state_d            = ST_UNLINK;
      end
      ST_INSERT: begin
        tag_we = 1'b1;
        tag_wa = free_q;
        tag_wd = {1'b1, key_q};
        if (occ_q == '0) begin
          tail_d = free_q;
        end else begin
          older_we = 1'b1;
          older_wa = free_q;
          older_wd = head_q;
          newer_we = 1'b1;
          newer_wa = head_q;
          newer_wd = free_q;
        end
        head_d  = free_q;
        occ_d   = occ_q + CW'(1);
        state_d = ST_DONE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      mode_q     <= MD_ACCESS;
      head_q     <= '0;
      tail_q     <= '0;
      occ_q      <= '0;
      wi_q       <= '0;
      pos_q      <= '0;
      fill_q     <= '0;
      cnt_q      <= '0;
      ins_q      <= '0;
      scan_q     <= '0;
      chk_idx_q  <= '0;
      chk_vld_q  <= 1'b0;
      free_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      mode_q     <= mode_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      occ_q      <= occ_d;
      wi_q       <= wi_d;
      pos_q      <= pos_d;
      fill_q     <= fill_d;
      cnt_q      <= cnt_d;
      ins_q      <= ins_d;
      scan_q     <= scan_d;
      chk_idx_q  <= chk_idx_d;
      chk_vld_q  <= chk_vld_d;
      free_vld_q <= free_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    s_q    <= s_d;
    o_q    <= o_d;
    n_q    <= n_d;
    free_q <= free_d;
    rsp_q  <= rsp_d;
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);
  assign rsp_o  = rsp_q;

  `FBP_ASSERT(a_occ_bound, clk_i, rst_ni, occ_q <= CAP_MAX)
  `FBP_ASSERT(a_ring_bound, clk_i, rst_ni, fill_q <= RING_FULL)
  `FBP_ASSERT(a_done_single, clk_i, rst_ni, done_o |=> !done_o)
  `FBP_ASSERT(a_victim_miss, clk_i, rst_ni, done_o && rsp_o.victim_valid |-> !rsp_o.hit)
  `FBP_ASSERT(a_promo_hit, clk_i, rst_ni, done_o && rsp_o.batch_promoted |-> rsp_o.hit)
  `FBP_ASSERT_NORST(a_reset_busy, clk_i, !rst_ni |=> busy)

endmodule
`default_nettype wire
